>>> rtl/dnsdup_pkg.sv
`default_nettype none

package dnsdup_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // Hit buffer geometry
   localparam int MAX_REPORT  = 63;
   localparam int HIT_IDX_W   = (MAX_REPORT > 1) ? $clog2(MAX_REPORT) : 1;
   localparam int HIT_CNT_W   = $clog2(MAX_REPORT + 1);
   localparam int HIT_DEPTH   = 2 ** HIT_IDX_W;

   // Field widths
   localparam int TID_W       = 16;
   localparam int ADDR_W      = 32;
   localparam int ENTRY_W     = TID_W + ADDR_W;

   // Control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT_READ,
      ST_EMIT_LOAD,
      ST_EMIT_CUR
   } state_type;

endpackage

`default_nettype wire

>>> rtl/dns_duplicate_response_detector_top.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   transaction_id, answer_addr, has_answer
// rsp_      out        rsp_valid/rsp_stall   reported_addr, is_current, duplicate_seen,
//                                            matches_dropped, last_of_run
//
// One transaction is handled at a time. A response with an answer walks the table
// memory (one read per cycle), then reads each stored match back from the hit buffer
// and emits it, then emits the current address, whose output load also writes the
// new pair into the table. A response without an answer is accepted and dropped.
// Reset clears the entry count and the sequencer; the memories are not cleared.
// rsp_stall only holds the output register, so the sequencer pauses in its emit states while a result waits.

module dns_duplicate_response_detector_top
   import dnsdup_pkg::*;
(
   input  wire                clock,
   input  wire                reset,

   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [TID_W-1:0]   req_transaction_id,
   input  wire  [ADDR_W-1:0]  req_answer_addr,
   input  wire                req_has_answer,

   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [ADDR_W-1:0]  rsp_reported_addr,
   output logic               rsp_is_current,
   output logic               rsp_duplicate_seen,
   output logic               rsp_matches_dropped,
   output logic               rsp_last_of_run
);

   // Storage
   logic [ENTRY_W-1:0]    table_mem [TABLE_DEPTH];
   logic [ADDR_W-1:0]     hit_mem   [HIT_DEPTH];

   // Sequencer and transaction context
   state_type             state_ff, state_in;
   logic [TID_W-1:0]      tid_ff, tid_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [HIT_CNT_W-1:0]  nhits_ff, nhits_in;
   logic [HIT_CNT_W-1:0]  emit_idx_ff, emit_idx_in;
   logic                  dup_ff, dup_in;
   logic                  dropped_ff, dropped_in;

   // Memory read data
   logic [ENTRY_W-1:0]    tbl_rd_ff;
   logic [ADDR_W-1:0]     hit_rd_ff;

   // Memory write ports
   logic                  tbl_we;
   logic                  hit_we;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic                  rsp_cur_ff, rsp_cur_in;
   logic                  rsp_dup_ff, rsp_dup_in;
   logic                  rsp_drop_ff, rsp_drop_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  slot_free;
   logic                  out_load;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Next state, memory writes and output loading
   always_comb begin
      state_in    = state_ff;
      tid_in      = tid_ff;
      addr_in     = addr_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      rd_pend_in  = 1'b0;
      nhits_in    = nhits_ff;
      emit_idx_in = emit_idx_ff;
      dup_in      = dup_ff;
      dropped_in  = dropped_ff;
      tbl_we      = 1'b0;
      hit_we      = 1'b0;
      out_load    = 1'b0;
      rsp_addr_in = rsp_addr_ff;
      rsp_cur_in  = rsp_cur_ff;
      rsp_dup_in  = rsp_dup_ff;
      rsp_drop_in = rsp_drop_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_has_answer) begin
               tid_in     = req_transaction_id;
               addr_in    = req_answer_addr;
               rd_idx_in  = '0;
               nhits_in   = '0;
               dup_in     = 1'b0;
               dropped_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one table read per cycle
            if (rd_idx_ff != count_ff) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            // check the entry read last cycle
            if (rd_pend_ff && (tbl_rd_ff[ENTRY_W-1:ADDR_W] == tid_ff)) begin
               dup_in = 1'b1;
               if (nhits_ff != HIT_CNT_W'(MAX_REPORT)) begin
                  hit_we   = 1'b1;
                  nhits_in = nhits_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end
            if ((rd_idx_ff == count_ff) && !rd_pend_ff) begin
               emit_idx_in = '0;
               state_in    = ST_EMIT_READ;
            end
         end

         ST_EMIT_READ: begin
            // hit buffer read is issued at emit_idx_ff
            if (emit_idx_ff == nhits_ff) begin
               state_in = ST_EMIT_CUR;
            end else begin
               state_in = ST_EMIT_LOAD;
            end
         end

         ST_EMIT_LOAD: begin
            if (slot_free) begin
               out_load    = 1'b1;
               rsp_addr_in = hit_rd_ff;
               rsp_cur_in  = 1'b0;
               rsp_dup_in  = dup_ff;
               rsp_drop_in = dropped_ff;
               rsp_last_in = 1'b0;
               emit_idx_in = emit_idx_ff + 1'b1;
               state_in    = ST_EMIT_READ;
            end
         end

         ST_EMIT_CUR: begin
            if (slot_free) begin
               out_load    = 1'b1;
               rsp_addr_in = addr_ff;
               rsp_cur_in  = 1'b1;
               rsp_dup_in  = dup_ff;
               rsp_drop_in = dropped_ff;
               rsp_last_in = 1'b1;
               // append the pair; a full table starts over empty
               tbl_we      = 1'b1;
               if (count_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  count_in = '0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Context and payload registers
   always_ff @(posedge clock) begin
      tid_ff      <= tid_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      nhits_ff    <= nhits_in;
      emit_idx_ff <= emit_idx_in;
      dup_ff      <= dup_in;
      dropped_ff  <= dropped_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_cur_ff  <= rsp_cur_in;
      rsp_dup_ff  <= rsp_dup_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[count_ff] <= {tid_ff, addr_ff};
      end
      tbl_rd_ff <= table_mem[rd_idx_ff];
   end

   // Hit buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (hit_we) begin
         hit_mem[nhits_ff[HIT_IDX_W-1:0]] <= tbl_rd_ff[ADDR_W-1:0];
      end
      hit_rd_ff <= hit_mem[emit_idx_ff[HIT_IDX_W-1:0]];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reported_addr   = rsp_addr_ff;
   assign rsp_is_current      = rsp_cur_ff;
   assign rsp_duplicate_seen  = rsp_dup_ff;
   assign rsp_matches_dropped = rsp_drop_ff;
   assign rsp_last_of_run     = rsp_last_ff;

endmodule

`default_nettype wire
